[rtl/rasp_pkg.sv]
// ----------------------------------------------------------------------------
// rasp_pkg
// Shared types and constants for the point rotate and scale block.
// ----------------------------------------------------------------------------
package rasp_pkg;

  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  // Trig series engine: 60 fraction bits, pi in that format
  localparam int unsigned WORK_BITS    = 60;
  localparam int unsigned THETA_SHIFT  = 15;
  localparam int unsigned TAYLOR_TERMS = 30;
  localparam logic [63:0] PI_WORK      = 64'h3243F6A8885A308D;

  typedef enum logic [2:0] {
    TRIG_IDLE,
    TRIG_TH_GO,
    TRIG_TH_WAIT,
    TRIG_TM_GO,
    TRIG_TM_WAIT,
    TRIG_DIV,
    TRIG_ACC,
    TRIG_FIN
  } trig_state_e;

  typedef struct packed {
    logic start;
    logic shift_long;
  } mul_ctrl_t;

endpackage

[rtl/rasp_wide_mul.sv]
// ----------------------------------------------------------------------------
// rasp_wide_mul
// Multi-cycle 64x64 multiplier, four 32x32 partial products, shifted result.
// ----------------------------------------------------------------------------
module rasp_wide_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rasp_pkg::mul_ctrl_t ctrl_i,
  input  logic [63:0]         a_i,
  input  logic [63:0]         b_i,
  output logic                done_o,
  output logic [63:0]         res_o
);

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [1:0]   step_q, step_d;
  logic         long_q, long_d;
  logic [63:0]  a_q, a_d, b_q, b_d;
  logic [127:0] acc_q, acc_d;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    a_part = step_q[1] ? a_q[63:32] : a_q[31:0];
    b_part = step_q[0] ? b_q[63:32] : b_q[31:0];
    pp     = a_part * b_part;
    case ({1'b0, step_q[1]} + {1'b0, step_q[0]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    long_d = long_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (busy_q) begin
      acc_d  = acc_q + pp_sh;
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (ctrl_i.start) begin
      busy_d = 1'b1;
      step_d = 2'd0;
      long_d = ctrl_i.shift_long;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    long_q <= long_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
  end

  assign done_o = done_q;
  assign res_o  = long_q ? acc_q[rasp_pkg::WORK_BITS +: 64]
                         : acc_q[rasp_pkg::THETA_SHIFT +: 64];

endmodule

[rtl/rasp_trig.sv]
// ----------------------------------------------------------------------------
// rasp_trig
// Sequencer for cosine and sine of a binary angle: Taylor series in fixed point
// with 60 fraction bits, shared multiplier, bit-serial divide, quadrant fold.
// ----------------------------------------------------------------------------
module rasp_trig #(
  parameter int unsigned TRIG_FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rasp_pkg::ANGLE_W-1:0]        angle_i,
  output logic                                busy_o,
  output logic signed [TRIG_FRACTION_BITS+1:0] cos_o,
  output logic signed [TRIG_FRACTION_BITS+1:0] sin_o
);

  localparam int unsigned CW       = TRIG_FRACTION_BITS + 2;
  localparam int unsigned RND_SH   = rasp_pkg::WORK_BITS - TRIG_FRACTION_BITS;
  localparam int unsigned NW       = $clog2(rasp_pkg::TAYLOR_TERMS + 1);
  localparam logic [63:0] ONE_WORK = 64'd1 << rasp_pkg::WORK_BITS;
  localparam logic [63:0] RND_HALF = 64'd1 << (RND_SH - 1);
  localparam logic [NW-1:0] N_LAST = NW'(rasp_pkg::TAYLOR_TERMS);
  localparam logic [5:0]  DIV_LAST = 6'd63;

  rasp_pkg::trig_state_e state_q, state_d;
  rasp_pkg::mul_ctrl_t   mul_ctrl;

  logic [1:0]        quad_q;
  logic [13:0]       r_q;
  logic [63:0]       theta_q, shreg_q, c_q, s_q;
  logic [NW-1:0]     n_q, rem_q;
  logic [5:0]        cnt_q;
  logic signed [CW-1:0] cos_q, sin_q, cos_d, sin_d;

  logic [63:0] mul_a, mul_b, mul_res;
  logic        mul_done;

  logic [NW:0]   rem_sh, rem_sub;
  logic          q_bit;
  logic [NW-1:0] rem_next;
  logic [63:0]   c_rnd, s_rnd;
  logic signed [CW-1:0] cr, sr;

  rasp_wide_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rasp_pkg::TRIG_IDLE:    if (start_i) state_d = rasp_pkg::TRIG_TH_GO;
      rasp_pkg::TRIG_TH_GO:   state_d = rasp_pkg::TRIG_TH_WAIT;
      rasp_pkg::TRIG_TH_WAIT: if (mul_done) state_d = rasp_pkg::TRIG_TM_GO;
      rasp_pkg::TRIG_TM_GO:   state_d = rasp_pkg::TRIG_TM_WAIT;
      rasp_pkg::TRIG_TM_WAIT: if (mul_done) state_d = rasp_pkg::TRIG_DIV;
      rasp_pkg::TRIG_DIV:     if (cnt_q == DIV_LAST) state_d = rasp_pkg::TRIG_ACC;
      rasp_pkg::TRIG_ACC: begin
        state_d = (n_q == N_LAST) ? rasp_pkg::TRIG_FIN : rasp_pkg::TRIG_TM_GO;
      end
      rasp_pkg::TRIG_FIN:     state_d = rasp_pkg::TRIG_IDLE;
      default:                state_d = rasp_pkg::TRIG_IDLE;
    endcase
  end

  always_comb begin
    busy_o              = (state_q != rasp_pkg::TRIG_IDLE);
    mul_ctrl.start      = (state_q == rasp_pkg::TRIG_TH_GO) ||
                          (state_q == rasp_pkg::TRIG_TM_GO);
    mul_ctrl.shift_long = (state_q == rasp_pkg::TRIG_TM_GO);
    mul_a = (state_q == rasp_pkg::TRIG_TH_GO) ? {50'd0, r_q} : shreg_q;
    mul_b = (state_q == rasp_pkg::TRIG_TH_GO) ? rasp_pkg::PI_WORK : theta_q;
  end

  // restoring divide of the product by the term index, one bit per cycle
  always_comb begin
    rem_sh   = {rem_q, shreg_q[63]};
    rem_sub  = rem_sh - {1'b0, n_q};
    q_bit    = (rem_sh >= {1'b0, n_q});
    rem_next = q_bit ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
  end

  always_comb begin
    c_rnd = c_q + RND_HALF;
    s_rnd = s_q + RND_HALF;
    cr    = $signed({1'b0, c_rnd[RND_SH +: TRIG_FRACTION_BITS+1]});
    sr    = $signed({1'b0, s_rnd[RND_SH +: TRIG_FRACTION_BITS+1]});
    case (quad_q)
      2'd0: begin cos_d = cr;  sin_d = sr;  end
      2'd1: begin cos_d = -sr; sin_d = cr;  end
      2'd2: begin cos_d = -cr; sin_d = -sr; end
      default: begin cos_d = sr; sin_d = -cr; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rasp_pkg::TRIG_IDLE;
      cos_q   <= CW'(64'd1 << TRIG_FRACTION_BITS);
      sin_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == rasp_pkg::TRIG_FIN) begin
        cos_q <= cos_d;
        sin_q <= sin_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rasp_pkg::TRIG_IDLE: begin
        if (start_i) begin
          quad_q <= angle_i[15:14];
          r_q    <= angle_i[13:0];
        end
      end
      rasp_pkg::TRIG_TH_WAIT: begin
        if (mul_done) begin
          theta_q <= mul_res;
          shreg_q <= ONE_WORK;
          c_q     <= ONE_WORK;
          s_q     <= '0;
          n_q     <= NW'(1);
        end
      end
      rasp_pkg::TRIG_TM_WAIT: begin
        if (mul_done) begin
          shreg_q <= mul_res;
          rem_q   <= '0;
          cnt_q   <= '0;
        end
      end
      rasp_pkg::TRIG_DIV: begin
        shreg_q <= {shreg_q[62:0], q_bit};
        rem_q   <= rem_next;
        cnt_q   <= cnt_q + 6'd1;
      end
      rasp_pkg::TRIG_ACC: begin
        if (n_q[0]) begin
          s_q <= n_q[1] ? s_q - shreg_q : s_q + shreg_q;
        end else begin
          c_q <= n_q[1] ? c_q - shreg_q : c_q + shreg_q;
        end
        n_q <= n_q + NW'(1);
      end
      default: ;
    endcase
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

[rtl/rasp_rot_pipe.sv]
// ----------------------------------------------------------------------------
// rasp_rot_pipe
// Five-stage point datapath: rotate products, sum, split scale multiply,
// recombine with rounding bias, saturate into the output register.
// ----------------------------------------------------------------------------
module rasp_rot_pipe #(
  parameter int unsigned TRIG_FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rasp_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [rasp_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [TRIG_FRACTION_BITS+1:0] cos_i,
  input  logic signed [TRIG_FRACTION_BITS+1:0] sin_i,
  input  logic [rasp_pkg::SCALE_W-1:0]         scale_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rasp_pkg::COORD_W-1:0]  rot_x_o,
  output logic signed [rasp_pkg::COORD_W-1:0]  rot_y_o,
  output logic                                 saturated_o
);

  localparam int unsigned NSTAGE = 5;
  localparam int unsigned CW  = TRIG_FRACTION_BITS + 2;
  localparam int unsigned PW  = rasp_pkg::COORD_W + CW;
  localparam int unsigned DW  = PW + 1;
  localparam int unsigned LW  = DW / 2;
  localparam int unsigned HW  = DW - LW;
  localparam int unsigned KW  = rasp_pkg::SCALE_W + 1;
  localparam int unsigned FW  = DW + KW;
  localparam int unsigned SH  = 16 + TRIG_FRACTION_BITS;
  localparam int unsigned VW  = FW - SH;
  localparam logic signed [FW-1:0] HALF = FW'(1) <<< (SH - 1);

  logic [NSTAGE-1:0] v_q, v_d, rdy;

  logic signed [PW-1:0]      xc_q, ys_q, xs_q, yc_q;
  logic signed [DW-1:0]      d0_q, d1_q;
  logic signed [LW+KW:0]     p0_lo_q, p1_lo_q;
  logic signed [HW+KW-1:0]   p0_hi_q, p1_hi_q;
  logic signed [FW-1:0]      f0_q, f1_q;
  logic signed [rasp_pkg::COORD_W-1:0] rx_q, ry_q;
  logic                      sat_q;

  logic signed [KW-1:0] k_s;
  logic signed [VW-1:0] v0, v1;
  logic                 sat0, sat1;
  logic signed [rasp_pkg::COORD_W-1:0] c0, c1;

  always_comb begin
    rdy[NSTAGE-1] = !v_q[NSTAGE-1] || out_ready_i;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
    v_d = v_q;
    if (rdy[0]) v_d[0] = in_valid_i;
    for (int i = 1; i < NSTAGE; i++) begin
      if (rdy[i]) v_d[i] = v_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign k_s = $signed({1'b0, scale_i});

  always_comb begin
    v0   = f0_q[FW-1:SH];
    v1   = f1_q[FW-1:SH];
    sat0 = !((&v0[VW-1:15]) || !(|v0[VW-1:15]));
    sat1 = !((&v1[VW-1:15]) || !(|v1[VW-1:15]));
    c0   = sat0 ? (v0[VW-1] ? 16'sh8000 : 16'sh7FFF) : v0[15:0];
    c1   = sat1 ? (v1[VW-1] ? 16'sh8000 : 16'sh7FFF) : v1[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      xc_q <= coord_x_i * cos_i;
      ys_q <= coord_y_i * sin_i;
      xs_q <= coord_x_i * sin_i;
      yc_q <= coord_y_i * cos_i;
    end
    if (rdy[1]) begin
      d0_q <= $signed({xc_q[PW-1], xc_q}) - $signed({ys_q[PW-1], ys_q});
      d1_q <= $signed({xs_q[PW-1], xs_q}) + $signed({yc_q[PW-1], yc_q});
    end
    if (rdy[2]) begin
      p0_lo_q <= $signed({1'b0, d0_q[LW-1:0]}) * k_s;
      p1_lo_q <= $signed({1'b0, d1_q[LW-1:0]}) * k_s;
      p0_hi_q <= $signed(d0_q[DW-1:LW]) * k_s;
      p1_hi_q <= $signed(d1_q[DW-1:LW]) * k_s;
    end
    if (rdy[3]) begin
      f0_q <= $signed({p0_hi_q, {LW{1'b0}}})
            + $signed({{(HW-1){p0_lo_q[LW+KW]}}, p0_lo_q}) + HALF;
      f1_q <= $signed({p1_hi_q, {LW{1'b0}}})
            + $signed({{(HW-1){p1_lo_q[LW+KW]}}, p1_lo_q}) + HALF;
    end
    if (rdy[4]) begin
      rx_q  <= c0;
      ry_q  <= c1;
      sat_q <= sat0 || sat1;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NSTAGE-1];
  assign rot_x_o     = rx_q;
  assign rot_y_o     = ry_q;
  assign saturated_o = sat_q;

endmodule

[rtl/rotate_and_scale_point.sv]
// ----------------------------------------------------------------------------
// rotate_and_scale_point
// Rotates points about the origin by a programmed angle and scales them.
// ----------------------------------------------------------------------------
// Points stream through a five-stage pipeline at one transfer per cycle while
// results are taken and no recompute runs; the output register holds a
// result until it is taken while the pipeline keeps filling. Register 0 is the
// 16-bit binary angle, register 1 the unsigned Q8.16 scale. Writing the angle
// starts a cosine and sine recompute on a shared multi-cycle multiplier and a
// bit-serial divider; during it in_ready_o and cfg_ready_o stay low. Results
// round half up and clamp to 16 bits, flagged by saturated_o.
module rotate_and_scale_point #(
  parameter int unsigned TRIG_FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rasp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rasp_pkg::SCALE_W-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rasp_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [rasp_pkg::COORD_W-1:0]  coord_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rasp_pkg::COORD_W-1:0]  rot_x_o,
  output logic signed [rasp_pkg::COORD_W-1:0]  rot_y_o,
  output logic                                 saturated_o
);

  localparam int unsigned CW = TRIG_FRACTION_BITS + 2;

  logic [rasp_pkg::SCALE_W-1:0] scale_q, scale_d;
  logic                 cfg_xfer, angle_wr, trig_busy, pipe_ready;
  logic signed [CW-1:0] cos_term, sin_term;

  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = !trig_busy;
  assign in_ready_o  = pipe_ready && !trig_busy;

  always_comb begin
    angle_wr = 1'b0;
    scale_d  = scale_q;
    if (cfg_xfer) begin
      unique case (cfg_index_i)
        rasp_pkg::REG_ROTATE_ANGLE: angle_wr = 1'b1;
        rasp_pkg::REG_SCALE_FACTOR: scale_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= rasp_pkg::SCALE_RESET;
    end else begin
      scale_q <= scale_d;
    end
  end

  rasp_trig #(
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (angle_wr),
    .angle_i (cfg_data_i[rasp_pkg::ANGLE_W-1:0]),
    .busy_o  (trig_busy),
    .cos_o   (cos_term),
    .sin_o   (sin_term)
  );

  rasp_rot_pipe #(
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i && !trig_busy),
    .in_ready_o  (pipe_ready),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .cos_i       (cos_term),
    .sin_i       (sin_term),
    .scale_i     (scale_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .saturated_o (saturated_o)
  );

  a_angle_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_wr |=> (!in_ready_o && !cfg_ready_o))
    else $error("input or config accepted during trig recompute");

  a_trig_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!trig_busy && !angle_wr) |=> ($stable(cos_term) && $stable(sin_term)))
    else $error("cos/sin changed outside a recompute");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (rot_x_o == 16'sh7FFF || rot_x_o == 16'sh8000 ||
       rot_y_o == 16'sh7FFF || rot_y_o == 16'sh8000))
    else $error("saturation flag without a clamped result");

endmodule
